### rtl/core/khrt_pkg.sv
`timescale 1ns / 1ps

package khrt_pkg;

  // Default table sizes
  localparam int SLOTS_DEF = 16;
  localparam int KEYS_DEF  = 256;

  // Fixed field widths
  localparam int JOY_W    = 4;
  localparam int CODE_W   = 16;
  localparam int MASK_W   = 32;
  localparam int BTN_W    = 8;
  localparam int KEY_W    = 8;
  localparam int STATUS_W = 2;
  localparam int REL_W    = 9;
  localparam int HOLD_W   = 5;

  // Hold count saturates here
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE      = 2'd0,
    ST_EMIT      = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNMATCHED = 2'd3
  } status_t;

  typedef enum logic {
    OP_EVENT     = 1'b0,
    OP_CLEAR_ALL = 1'b1
  } op_t;

endpackage

### rtl/core/khrt_ram.sv
`timescale 1ns / 1ps

module khrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/key_hold_refcount_table_top.sv
`timescale 1ns / 1ps

// Key hold reference-count table.
//
// Request channel: drive op and the source/key fields with start high; the
// request is taken at the clock edge where start is high and busy is low.
// busy stays high through the lookup and update states after a request is
// taken, so the next request is taken only once the previous one is through.
// Result channel: done pulses for one cycle, registered at the end of the
// update state, with status, event_key, event_press and released_count. Exactly one
// result per request. The receiver cannot stall; the result is gone after
// that cycle, and a new request may be taken in the same cycle it shows.
// The hold-count memory sets the pace: the count of the key is read (while the
// slot table is compared in parallel), then modified and written back.
// Reset (rst, synchronous) empties the slot table, marks every hold count as
// zero through per-key valid bits and zeroes the held-key counter; no
// clearing pass is needed. The release-all op does the same in one request
// and reports how many keys were held, taken from a running counter.

module key_hold_refcount_table_top
  import khrt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int KEYS  = KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [JOY_W-1:0]    source_joystick,
  input  logic [CODE_W-1:0]   source_code,
  input  logic [MASK_W-1:0]   source_mask,
  input  logic [BTN_W-1:0]    source_button,
  input  logic [KEY_W-1:0]    key_code,
  input  logic                is_press,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    event_key,
  output logic                event_press,
  output logic [REL_W-1:0]    released_count
);

  localparam int KW = $clog2(KEYS);
  localparam int CW = $clog2(KEYS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic [JOY_W-1:0]  joystick;
    logic [CODE_W-1:0] code;
    logic [MASK_W-1:0] mask;
    logic [BTN_W-1:0]  button;
    logic [KEY_W-1:0]  key;
  } source_t;

  state_t state;

  // Latched request
  logic    req_op;
  source_t req_src;
  logic    req_press;

  // Slot table: each slot is compared in place
  logic [SLOTS-1:0] slot_active;
  source_t          slot_src [SLOTS];

  // Per-key valid bits in front of the hold-count memory
  logic [KEYS-1:0]  cnt_valid;
  logic             cnt_valid_q;

  logic [CW-1:0]    held;

  // Lookup results, registered at the end of the lookup cycle
  logic [SLOTS-1:0] match_vec, match_q;
  logic [SLOTS-1:0] free_q, free_oh;

  // Hold-count memory
  logic [KW-1:0]     cnt_addr;
  logic [HOLD_W-1:0] cnt_rdata;
  logic              cnt_we;
  logic [HOLD_W-1:0] cnt_wdata;

  // Update decisions
  logic              key_ok;
  logic [HOLD_W-1:0] prev;
  status_t           upd_status;
  logic              upd_emit_press;
  logic              ins_en;
  logic              rel_en;
  logic              held_inc;
  logic              held_dec;
  logic              clr_all;
  logic              upd_en;

  assign busy     = (state != S_IDLE);
  assign cnt_addr = req_src.key[KW-1:0];
  assign upd_en   = (state == S_UPDATE);

  khrt_ram #(
    .WIDTH (HOLD_W),
    .DEPTH (KEYS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_addr),
    .wdata (cnt_wdata),
    .raddr (cnt_addr),
    .rdata (cnt_rdata)
  );

  // Compare the request against every slot in parallel
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match_vec[s] = slot_active[s] && (slot_src[s] == req_src);
    end
  end

  // Lowest free slot as a one-hot vector
  assign free_oh = free_q & (~free_q + SLOTS'(1));

  assign key_ok = (req_src.key != '0) && ({1'b0, req_src.key} < (KEY_W + 1)'(KEYS));
  assign prev   = cnt_valid_q ? cnt_rdata : '0;

  always_comb begin
    upd_status     = ST_NONE;
    upd_emit_press = 1'b0;
    ins_en         = 1'b0;
    rel_en         = 1'b0;
    held_inc       = 1'b0;
    held_dec       = 1'b0;
    clr_all        = 1'b0;
    cnt_we         = 1'b0;
    cnt_wdata      = prev;
    if (upd_en) begin
      if (req_op == OP_CLEAR_ALL) begin
        clr_all = 1'b1;
      end else if (key_ok) begin
        if (req_press) begin
          priority if (match_q != '0) begin
            upd_status = ST_NONE;
          end else if (free_q == '0) begin
            upd_status = ST_OVERFLOW;
          end else begin
            ins_en = 1'b1;
            if (prev != HOLD_MAX) begin
              cnt_we    = 1'b1;
              cnt_wdata = prev + HOLD_W'(1);
            end
            if (prev == '0) begin
              upd_status     = ST_EMIT;
              upd_emit_press = 1'b1;
              held_inc       = 1'b1;
            end
          end
        end else begin
          priority if (match_q == '0) begin
            upd_status = ST_UNMATCHED;
          end else if (prev == '0) begin
            rel_en     = 1'b1;
            upd_status = ST_UNMATCHED;
          end else begin
            rel_en    = 1'b1;
            cnt_we    = 1'b1;
            cnt_wdata = prev - HOLD_W'(1);
            if (prev == HOLD_W'(1)) begin
              upd_status = ST_EMIT;
              held_dec   = 1'b1;
            end
          end
        end
      end
    end
  end

  // Sequencer, request latch and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      status         <= ST_NONE;
      event_key      <= '0;
      event_press    <= 1'b0;
      released_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state          <= S_IDLE;
          done           <= 1'b1;
          status         <= upd_status;
          event_key      <= (upd_status == ST_EMIT) ? req_src.key : '0;
          event_press    <= upd_emit_press;
          released_count <= clr_all ? REL_W'(held) : '0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the request and the lookup results
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_op           <= op;
      req_src.joystick <= source_joystick;
      req_src.code     <= source_code;
      req_src.mask     <= source_mask;
      req_src.button   <= source_button;
      req_src.key      <= key_code;
      req_press        <= is_press;
    end
    if (state == S_LOOK) begin
      match_q     <= match_vec;
      free_q      <= ~slot_active;
      cnt_valid_q <= cnt_valid[cnt_addr];
    end
  end

  // Slot table and hold-count valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      cnt_valid   <= '0;
      held        <= '0;
    end else if (clr_all) begin
      slot_active <= '0;
      cnt_valid   <= '0;
      held        <= '0;
    end else begin
      if (ins_en) begin
        slot_active <= slot_active | free_oh;
      end else if (rel_en) begin
        slot_active <= slot_active & ~match_q;
      end
      if (cnt_we) begin
        cnt_valid[cnt_addr] <= 1'b1;
      end
      if (held_inc) begin
        held <= held + CW'(1);
      end else if (held_dec) begin
        held <= held - CW'(1);
      end
    end
  end

  // Slot payload: valid only where the slot is active
  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (ins_en && free_oh[s]) begin
        slot_src[s] <= req_src;
      end
    end
  end

`ifndef SYNTHESIS
  // A contributor never holds two slots
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> $onehot0(match_q))
    else $error("more than one slot matches the request");

  // Each result follows an update cycle
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("result strobe without an update");

  // A taken request starts the lookup
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_LOOK))
    else $error("request taken but lookup not started");

  // The held-key counter stays within the key range
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(KEYS))
    else $error("held-key counter out of range");

  // An emitted event always names a real key
  a_emit_key: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMIT) |-> (event_key != '0))
    else $error("event emitted for key zero");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import khrt_pkg::*;

  localparam int N_SLOTS         = SLOTS_DEF;
  localparam int N_KEYS          = KEYS_DEF;
  localparam int RANDOM_REQUESTS = 1525;
  localparam int CALM_TAIL       = 150;   // last requests go back to back
  localparam int QUIET_LIMIT     = 500;   // cycles with no handshake before giving up
  localparam int DRAIN_LIMIT     = 200;
  localparam int POOL_SIZE       = 24;    // more contributors than slots, so overflow happens
  localparam int KEY_POOL        = 6;     // few keys, so contributors share them

  // One contributor: everything that identifies a slot.
  typedef struct packed {
    logic [JOY_W-1:0]  joystick;
    logic [CODE_W-1:0] code;
    logic [MASK_W-1:0] mask;
    logic [BTN_W-1:0]  button;
    logic [KEY_W-1:0]  key;
  } source_t;

  typedef struct packed {
    op_t     op;
    source_t src;
    logic    is_press;
  } request_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic             press;
    logic [REL_W-1:0] released;
  } key_result_t;

  // Mirror of the slot table and hold counts, plus the results still owed.
  class key_hold_scoreboard;
    bit                slot_used [N_SLOTS];
    source_t           slot_src  [N_SLOTS];
    logic [HOLD_W-1:0] hold      [N_KEYS];
    key_result_t       owed_results [$];
    int                errors;

    function new();
      clear_table();
      errors = 0;
    endfunction

    function void clear_table();
      foreach (slot_used[s]) begin
        slot_used[s] = 1'b0;
        slot_src[s]  = '0;
      end
      foreach (hold[k]) hold[k] = '0;
    endfunction

    // Work out what an accepted request must produce and update the mirror.
    function void note_request(request_t r);
      key_result_t res;
      int          open_slot;
      int          match;
      int          held;
      logic [HOLD_W-1:0] prev;
      res = '0;
      res.status = ST_NONE;
      if (r.op == OP_CLEAR_ALL) begin
        held = 0;
        foreach (hold[k]) if (hold[k] != 0) held++;
        res.released = REL_W'(held);
        clear_table();
      end else if (r.src.key != 0 && int'(r.src.key) < N_KEYS) begin
        open_slot = -1;
        match     = -1;
        for (int s = 0; s < N_SLOTS; s++) begin
          if (!slot_used[s] && open_slot < 0) open_slot = s;
          if (slot_used[s] && slot_src[s] == r.src) begin
            match = s;
            break;
          end
        end
        if (r.is_press) begin
          if (match >= 0) begin
            res.status = ST_NONE;
          end else if (open_slot < 0) begin
            res.status = ST_OVERFLOW;
          end else begin
            prev = hold[r.src.key];
            slot_used[open_slot] = 1'b1;
            slot_src[open_slot]  = r.src;
            if (prev < HOLD_MAX) hold[r.src.key] = prev + 1'b1;
            if (prev == 0) begin
              res.status = ST_EMIT;
              res.key    = r.src.key;
              res.press  = 1'b1;
            end
          end
        end else begin
          if (match < 0) begin
            res.status = ST_UNMATCHED;
          end else begin
            slot_used[match] = 1'b0;
            if (hold[r.src.key] == 0) begin
              res.status = ST_UNMATCHED;
            end else begin
              hold[r.src.key] = hold[r.src.key] - 1'b1;
              if (hold[r.src.key] == 0) begin
                res.status = ST_EMIT;
                res.key    = r.src.key;
                res.press  = 1'b0;
              end
            end
          end
        end
      end
      owed_results.push_back(res);
    endfunction

    // Compare a result with the oldest one owed.
    function void check_result(key_result_t got);
      key_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with no request waiting: status %0d", got.status);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.key !== want.key) begin
        $error("event_key: expected %0d, got %0d", want.key, got.key);
        errors++;
      end
      if (got.press !== want.press) begin
        $error("event_press: expected %0d, got %0d", want.press, got.press);
        errors++;
      end
      if (got.released !== want.released) begin
        $error("released_count: expected %0d, got %0d", want.released, got.released);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction
  endclass

  // Drive every input to a known value from time zero.
  logic                clk             = 1'b0;
  logic                rst             = 1'b1;
  logic                start           = 1'b0;
  logic                op              = OP_EVENT;
  logic [JOY_W-1:0]    source_joystick = '0;
  logic [CODE_W-1:0]   source_code     = '0;
  logic [MASK_W-1:0]   source_mask     = '0;
  logic [BTN_W-1:0]    source_button   = '0;
  logic [KEY_W-1:0]    key_code        = '0;
  logic                is_press        = 1'b0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    event_key;
  logic                event_press;
  logic [REL_W-1:0]    released_count;

  key_hold_scoreboard sb;
  int                 quiet_cycles = 0;

  source_t          src_pool [POOL_SIZE];
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_hold_refcount_table_top uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .source_joystick (source_joystick),
    .source_code     (source_code),
    .source_mask     (source_mask),
    .source_button   (source_button),
    .key_code        (key_code),
    .is_press        (is_press),
    .done            (done),
    .status          (status),
    .event_key       (event_key),
    .event_press     (event_press),
    .released_count  (released_count)
  );

  // Sample at the rising edge: note each taken request, check each result,
  // and stop the run if the handshakes go quiet for too long.
  always @(posedge clk) begin
    request_t    taken;
    key_result_t got;
    if (!rst) begin
      if (start && !busy) begin
        taken.op           = op_t'(op);
        taken.src.joystick = source_joystick;
        taken.src.code     = source_code;
        taken.src.mask     = source_mask;
        taken.src.button   = source_button;
        taken.src.key      = key_code;
        taken.is_press     = is_press;
        sb.note_request(taken);
      end
      if (done) begin
        got.status   = status_t'(status);
        got.key      = event_key;
        got.press    = event_press;
        got.released = released_count;
        sb.check_result(got);
      end
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Fresh random contributor with a key from the shared key pool.
  function automatic source_t pool_source();
    source_t s;
    s.joystick = JOY_W'($urandom);
    s.code     = CODE_W'($urandom);
    s.mask     = MASK_W'($urandom);
    s.button   = BTN_W'($urandom);
    s.key      = key_pool[$urandom_range(0, KEY_POOL - 1)];
    return s;
  endfunction

  // Pick new keys and new contributors; done at start and after a clear.
  function automatic void refresh_pools();
    foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom_range(1, 255));
    foreach (src_pool[p]) src_pool[p] = pool_source();
  endfunction

  function automatic request_t make_req(op_t o, source_t s, logic press);
    request_t r;
    r.op       = o;
    r.src      = s;
    r.is_press = press;
    return r;
  endfunction

  // Mostly press/release from the pool so slots fill and counts stack up;
  // the rest is noise, key 0 and an occasional clear.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick       = $urandom_range(0, 99);
    r.op       = OP_EVENT;
    r.is_press = ($urandom_range(0, 99) < 55);
    if (pick < 2) begin
      r.op  = OP_CLEAR_ALL;
      r.src = pool_source();
      r.src.key = KEY_W'($urandom);
      refresh_pools();
    end else if (pick < 12) begin
      r.src = pool_source();
      r.src.key = ($urandom_range(0, 3) == 0) ? '0 : KEY_W'($urandom);
    end else begin
      // Swap out a contributor now and then, leaving its slot stuck.
      if ($urandom_range(0, 19) == 0) src_pool[$urandom_range(0, POOL_SIZE - 1)] = pool_source();
      r.src = src_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return r;
  endfunction

  // Hold the request until it is taken; leave start high for the caller.
  task automatic send(request_t r);
    start           <= 1'b1;
    op              <= r.op;
    source_joystick <= r.src.joystick;
    source_code     <= r.src.code;
    source_mask     <= r.src.mask;
    source_button   <= r.src.button;
    key_code        <= r.src.key;
    is_press        <= r.is_press;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic directed_requests();
    source_t a;
    source_t b;
    source_t z;
    source_t s;
    a = '1;
    b = a;
    b.button = '0;
    z = '0;
    // Clear on an empty table, with every other field high.
    send(make_req(OP_CLEAR_ALL, '1, 1'b1));
    // Key 0 is ignored both ways.
    send(make_req(OP_EVENT, z, 1'b1));
    send(make_req(OP_EVENT, z, 1'b0));
    // Two contributors on key 255: one down event, one repeated press,
    // one up event, then a release with nothing left to match.
    send(make_req(OP_EVENT, a, 1'b1));
    send(make_req(OP_EVENT, a, 1'b1));
    send(make_req(OP_EVENT, b, 1'b1));
    send(make_req(OP_EVENT, a, 1'b0));
    send(make_req(OP_EVENT, b, 1'b0));
    send(make_req(OP_EVENT, b, 1'b0));
    pause(3);
    // Fill every slot, then one more press overflows.
    z.key = 8'd1;
    send(make_req(OP_EVENT, z, 1'b1));
    for (int i = 1; i < N_SLOTS; i++) begin
      s          = '0;
      s.joystick = JOY_W'(i);
      s.code     = CODE_W'(i * 4099);
      s.mask     = MASK_W'(1) << i;
      s.button   = BTN_W'(i * 17);
      s.key      = (i % 2 == 0) ? 8'd1 : 8'h80;
      send(make_req(OP_EVENT, s, 1'b1));
    end
    send(make_req(OP_EVENT, a, 1'b1));
    // Clear with keys held reports how many.
    send(make_req(OP_CLEAR_ALL, '0, 1'b0));
  endtask

  initial begin
    request_t r;
    int       drain_cycles;
    sb = new();
    refresh_pools();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    directed_requests();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      r = random_request();
      send(r);
      // Idle in bursts except near the end, where requests go back to back.
      if (n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 6));
    end
    start <= 1'b0;

    // Drain the outstanding results, then give the pipeline a few more cycles.
    drain_cycles = 0;
    while (sb.outstanding() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $error("%0d results never arrived", sb.outstanding());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
